// ===== design/mrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrc_pkg: shared types and constants of the read response checker
// Frame constants, result codes, item and result structs, CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    localparam int MAX_REGISTERS = 125;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING   = 8'h03;
    localparam logic [7:0] FUNC_EXCEPTION_FLAG = 8'h80;

    // address, function, byte count and two CRC bytes
    localparam logic [7:0] FRAME_OVERHEAD = 8'd5;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ID   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_COUNT = 2'd1;

    localparam logic CMD_BYTE      = 1'b0;
    localparam logic CMD_FRAME_END = 1'b1;

    typedef enum logic {
        KIND_WORD   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_EXCEPTION       = 3'd1,
        ST_SHORT           = 3'd2,
        ST_CRC_ERROR       = 3'd3,
        ST_HEADER_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] slave_id;
        logic [6:0] word_count;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        status_t     status;
        logic [7:0]  exception_code;
        logic [7:0]  byte_count;
        logic [31:0] ok_total;
        logic [31:0] error_total;
    } result_t;

    // CRC-16/MODBUS over one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/mrrc_rx_if.sv =====
// ----------------------------------------------------------------------------
// mrrc_rx_if: received item channel
// Valid/ready channel carrying a command bit and a received byte.
// ----------------------------------------------------------------------------
interface mrrc_rx_if import mrrc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

// ===== design/mrrc_res_if.sv =====
// ----------------------------------------------------------------------------
// mrrc_res_if: result channel
// Valid/ready channel carrying register words and frame status items.
// ----------------------------------------------------------------------------
interface mrrc_res_if import mrrc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  reg_index;
    logic [15:0] reg_value;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic [7:0]  byte_count;
    logic [31:0] ok_total;
    logic [31:0] error_total;

    modport source (
        output valid, output kind, output reg_index, output reg_value, output status,
        output exception_code, output byte_count, output ok_total, output error_total,
        input ready
    );
    modport sink (
        input valid, input kind, input reg_index, input reg_value, input status,
        input exception_code, input byte_count, input ok_total, input error_total,
        output ready
    );
endinterface

// ===== design/mrrc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mrrc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mrrc_cfg_if import mrrc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/mrrc_in_stage.sv =====
// ----------------------------------------------------------------------------
// mrrc_in_stage: input register
// Holds one received item until the frame core consumes it.
// ----------------------------------------------------------------------------
module mrrc_in_stage
    import mrrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  rx_item_t in_item,
    output logic     in_ready,
    input  logic     advance,
    output logic     item_valid,
    output rx_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;

    // refill in the same cycle the held item moves on
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/mrrc_frame_core.sv =====
// ----------------------------------------------------------------------------
// mrrc_frame_core: frame state and result logic
// Tracks CRC, header and trailing bytes of one frame; forms words and status.
// ----------------------------------------------------------------------------
module mrrc_frame_core
    import mrrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  rx_item_t item,
    input  cfg_t     cfg,
    output logic     has_result,
    output result_t  result
);

    logic [7:0]       seen_reg,  seen_next;
    logic [15:0]      crc_reg,   crc_next;
    logic [2:0][7:0]  hdr_reg,   hdr_next;
    logic [7:0]       pend_reg,  pend_next;
    logic [15:0]      trail_reg, trail_next;
    logic             done_reg,  done_next;
    logic [31:0]      good_reg,  good_next;
    logic [31:0]      bad_reg,   bad_next;

    logic [6:0]       eff_count;
    logic [7:0]       frame_len;
    logic [8:0]       seen_inc;
    logic             in_body;
    logic             byte_last;
    logic [7:0]       word_off;

    logic [2:0][7:0]  b_hdr;
    logic [15:0]      b_crc;
    logic [15:0]      b_trail;

    logic [7:0]       f_seen;
    logic [2:0][7:0]  f_hdr;
    logic [15:0]      f_crc;
    logic [15:0]      f_trail;
    status_t          f_status;
    result_t          status_item;
    logic [31:0]      good_inc, bad_inc;

    assign eff_count = (cfg.word_count > 7'(MAX_REGISTERS)) ? 7'(MAX_REGISTERS)
                                                           : cfg.word_count;
    assign frame_len = FRAME_OVERHEAD + {eff_count, 1'b0};
    assign seen_inc  = {1'b0, seen_reg} + 9'd1;
    assign in_body   = ({1'b0, seen_reg} + 9'd2) < {1'b0, frame_len};
    assign byte_last = seen_inc >= {1'b0, frame_len};
    assign word_off  = seen_reg - 8'd4;

    // state as it stands after taking the current byte
    always_comb
    begin
        b_hdr = hdr_reg;
        if (seen_reg < 8'd3)
        begin
            b_hdr[seen_reg[1:0]] = item.rx_byte;
        end
        b_crc   = in_body ? crc16_byte(crc_reg, item.rx_byte) : crc_reg;
        b_trail = {item.rx_byte, trail_reg[15:8]};
    end

    // judge the frame: end command looks at held state, last byte at updated state
    always_comb
    begin
        if (item.command == CMD_FRAME_END)
        begin
            f_seen  = seen_reg;
            f_hdr   = hdr_reg;
            f_crc   = crc_reg;
            f_trail = trail_reg;
        end
        else
        begin
            f_seen  = seen_inc[7:0];
            f_hdr   = b_hdr;
            f_crc   = b_crc;
            f_trail = b_trail;
        end

        if (f_seen == FRAME_OVERHEAD && f_hdr[0] == cfg.slave_id &&
            f_hdr[1] == (FUNC_READ_HOLDING | FUNC_EXCEPTION_FLAG))
        begin
            f_status = ST_EXCEPTION;
        end
        else if (f_seen != frame_len)
        begin
            f_status = ST_SHORT;
        end
        else if (f_trail != f_crc)
        begin
            f_status = ST_CRC_ERROR;
        end
        else if (f_hdr[0] != cfg.slave_id || f_hdr[1] != FUNC_READ_HOLDING ||
                 f_hdr[2] != {eff_count, 1'b0})
        begin
            f_status = ST_HEADER_MISMATCH;
        end
        else
        begin
            f_status = ST_OK;
        end

        good_inc = good_reg + ((f_status == ST_OK) ? 32'd1 : 32'd0);
        bad_inc  = bad_reg  + ((f_status == ST_OK) ? 32'd0 : 32'd1);

        status_item.kind           = KIND_STATUS;
        status_item.reg_index      = '0;
        status_item.reg_value      = '0;
        status_item.status         = f_status;
        status_item.exception_code = (f_status == ST_EXCEPTION) ? f_hdr[2] : 8'h00;
        status_item.byte_count     = f_seen;
        status_item.ok_total       = good_inc;
        status_item.error_total    = bad_inc;
    end

    always_comb
    begin
        seen_next  = seen_reg;
        crc_next   = crc_reg;
        hdr_next   = hdr_reg;
        pend_next  = pend_reg;
        trail_next = trail_reg;
        done_next  = done_reg;
        good_next  = good_reg;
        bad_next   = bad_reg;
        has_result = 1'b0;

        result.kind           = KIND_WORD;
        result.reg_index      = 7'(word_off[7:1]);
        result.reg_value      = {pend_reg, item.rx_byte};
        result.status         = ST_OK;
        result.exception_code = 8'h00;
        result.byte_count     = seen_inc[7:0];
        result.ok_total       = good_reg;
        result.error_total    = bad_reg;

        case (item.command)
            CMD_FRAME_END:
            begin
                seen_next  = '0;
                crc_next   = CRC_INIT;
                hdr_next   = '0;
                pend_next  = '0;
                trail_next = '0;
                done_next  = 1'b0;
                if (!done_reg)
                begin
                    has_result = 1'b1;
                    result     = status_item;
                    good_next  = good_inc;
                    bad_next   = bad_inc;
                end
            end
            CMD_BYTE:
            begin
                // drop bytes after a complete frame
                if (!done_reg)
                begin
                    seen_next  = seen_inc[7:0];
                    hdr_next   = b_hdr;
                    crc_next   = b_crc;
                    trail_next = b_trail;
                    if (in_body && seen_reg >= 8'd3)
                    begin
                        if (seen_reg[0])
                        begin
                            pend_next = item.rx_byte;
                        end
                        else
                        begin
                            has_result = 1'b1;
                        end
                    end
                    if (byte_last)
                    begin
                        done_next  = 1'b1;
                        has_result = 1'b1;
                        result     = status_item;
                        good_next  = good_inc;
                        bad_next   = bad_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            crc_reg   <= CRC_INIT;
            hdr_reg   <= '0;
            pend_reg  <= '0;
            trail_reg <= '0;
            done_reg  <= 1'b0;
            good_reg  <= '0;
            bad_reg   <= '0;
        end
        else if (advance)
        begin
            seen_reg  <= seen_next;
            crc_reg   <= crc_next;
            hdr_reg   <= hdr_next;
            pend_reg  <= pend_next;
            trail_reg <= trail_next;
            done_reg  <= done_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

// ===== design/mrrc_out_stage.sv =====
// ----------------------------------------------------------------------------
// mrrc_out_stage: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module mrrc_out_stage
    import mrrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    has_result,
    input  result_t result,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_item
);

    logic    valid_reg;
    logic    valid_next;
    result_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance && has_result)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            item_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/modbus_read_response_checker.sv =====
// ----------------------------------------------------------------------------
// modbus_read_response_checker: function-3 response checker, one byte per item
// Checks a read-holding-registers response as it arrives and reports words
// and a final frame status.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : items with command (0 byte, 1 frame end on gap or timeout) and rx_byte.
//   res : register words (kind 0) as each pair completes, tentative until the
//         frame status item (kind 1) that closes the frame.
//   cfg : register writes, index 0 slave_id, index 1 word count; always
//         ready. Write only while no item is in flight.
//   An accepted item passes the input register, then the result register,
//   which drives res.valid.
//   Throughput: one item per cycle while the result register is free or
//   draining; the CRC byte update and the header compares sit in a single stage.
//   A full result register that the receiver stalls holds its item; the input
//   register then fills and rx.ready drops until res.ready returns. Bytes that
//   make no result also wait behind a full result register that is stalled.
//   Reset: counters cleared, slave_id 1, word count 17, frame state empty.
// ----------------------------------------------------------------------------
module modbus_read_response_checker
    import mrrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mrrc_rx_if.sink       rx,
    mrrc_res_if.source    res,
    mrrc_cfg_if.sink      cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    rx_item_t in_item;
    rx_item_t item;
    logic     item_valid;
    logic     advance;
    logic     has_result;
    result_t  result;
    result_t  out_item;
    logic     out_valid;

    // configuration: take every write, ignore unknown indexes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SLAVE_ID:   cfg_next.slave_id   = cfg.data;
                CFG_WORD_COUNT: cfg_next.word_count = cfg.data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_id   <= 8'd1;
            cfg_reg.word_count <= 7'd17;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // advance the held byte whenever the result register is free or draining
    assign advance = item_valid && (!out_valid || res.ready);

    assign in_item.command = rx.command;
    assign in_item.rx_byte = rx.rx_byte;

    mrrc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rx.valid),
        .in_item    (in_item),
        .in_ready   (rx.ready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mrrc_frame_core u_frame_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .cfg        (cfg_reg),
        .has_result (has_result),
        .result     (result)
    );

    mrrc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .has_result (has_result),
        .result     (result),
        .out_ready  (res.ready),
        .out_valid  (out_valid),
        .out_item   (out_item)
    );

    assign res.valid          = out_valid;
    assign res.kind           = out_item.kind;
    assign res.reg_index      = out_item.reg_index;
    assign res.reg_value      = out_item.reg_value;
    assign res.status         = out_item.status;
    assign res.exception_code = out_item.exception_code;
    assign res.byte_count     = out_item.byte_count;
    assign res.ok_total       = out_item.ok_total;
    assign res.error_total    = out_item.error_total;

    // a word item sits right after the header: byte count is 5 + 2 * index
    a_word_position: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_WORD) |->
            ({res.reg_index, 1'b0} + 8'd5) == res.byte_count && res.status == ST_OK)
        else $error("word item position does not match its byte count");

    // an exception is always a five byte frame
    a_exception_length: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_STATUS && res.status == ST_EXCEPTION) |->
            res.byte_count == FRAME_OVERHEAD)
        else $error("exception status on a frame that is not five bytes");

    // exception code only travels with an exception status
    a_code_only_on_exception: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !(res.kind == KIND_STATUS && res.status == ST_EXCEPTION)) |->
            res.exception_code == 8'h00)
        else $error("exception code set outside an exception status");

    // the input register never drops an item: it only empties by advancing
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !advance) |=> item_valid && $stable(item))
        else $error("held input item lost or changed");

endmodule

// ===== tb/modbus_read_response_checker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_read_response_checker_tb: self-checking bench of the read response checker
// Walks a short scripted sequence of response bytes and end commands, then
// random well-formed, damaged and noisy frames over many register settings.
// Every result item is checked against the bench's frame tracker or a typed script row.
// ----------------------------------------------------------------------------
module modbus_read_response_checker_tb;
    import mrrc_pkg::*;

    localparam logic [7:0] FUNC_EXCEPTION_REPLY = FUNC_READ_HOLDING | FUNC_EXCEPTION_FLAG;
    localparam int unsigned ITEM_TARGET = 2000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam result_t NO_RESULT = '0;

    // Script steps: plain bytes, end commands, CRC bytes taken from the
    // tracker's running CRC, and register writes.
    typedef enum logic [2:0] {
        OP_BYTE,
        OP_END,
        OP_CRC_LO,
        OP_CRC_BAD,
        OP_CRC_HI,
        OP_SET_SLAVE,
        OP_SET_COUNT
    } script_op_t;

    // A row with typed set carries a status item that is read off directly.
    typedef struct packed {
        script_op_t op;
        logic [7:0] value;
        logic       typed;
        status_t    st;
        logic [7:0] code;
        logic [7:0] cnt;
        logic [7:0] ok;
        logic [7:0] err;
    } script_row_t;

    localparam int SCRIPT_LEN = 31;

    script_row_t script [SCRIPT_LEN] = '{
        // end command on an empty frame: short, first error
        '{OP_END,       8'h00, 1'b1, ST_SHORT,           8'h00, 8'd0, 8'd0, 8'd1},
        // no registers: a frame is address, function, count and CRC
        '{OP_SET_COUNT, 8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'h01, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE, FUNC_READ_HOLDING, 1'b0, ST_OK,       8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_CRC_LO,    8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_CRC_HI,    8'h00, 1'b1, ST_OK,              8'h00, 8'd5, 8'd1, 8'd1},
        // byte after a complete frame, then the end command: both silent
        '{OP_BYTE,      8'hFF, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_END,       8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        // exception reply, CRC not checked
        '{OP_BYTE,      8'h01, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE, FUNC_EXCEPTION_REPLY, 1'b0, ST_OK,    8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'h02, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'hAA, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'h55, 1'b1, ST_EXCEPTION,       8'h02, 8'd5, 8'd1, 8'd2},
        '{OP_END,       8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        // wrong address with a good CRC
        '{OP_BYTE,      8'h07, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE, FUNC_READ_HOLDING, 1'b0, ST_OK,       8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_CRC_LO,    8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_CRC_HI,    8'h00, 1'b1, ST_HEADER_MISMATCH, 8'h00, 8'd5, 8'd1, 8'd3},
        '{OP_END,       8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        // top address, one register, damaged CRC
        '{OP_SET_SLAVE, 8'hFF, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_SET_COUNT, 8'h01, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'hFF, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE, FUNC_READ_HOLDING, 1'b0, ST_OK,       8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'h02, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'hFF, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_BYTE,      8'hFF, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_CRC_BAD,   8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0},
        '{OP_CRC_HI,    8'h00, 1'b1, ST_CRC_ERROR,       8'h00, 8'd7, 8'd1, 8'd4},
        '{OP_END,       8'h00, 1'b0, ST_OK,              8'h00, 8'd0, 8'd0, 8'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    mrrc_rx_if  rx_ch ();
    mrrc_res_if res_ch ();
    mrrc_cfg_if cfg_ch ();

    modbus_read_response_checker DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Frame tracker: register copies and per-frame state of the block
    // ------------------------------------------------------------------------
    logic [7:0]  cfg_slave;
    logic [6:0]  cfg_count;
    int unsigned frame_len_seen;
    logic [15:0] crc_acc;
    logic [7:0]  hdr_bytes [3];
    logic [7:0]  hi_byte;
    logic [15:0] last_two;
    logic        frame_closed;
    logic [31:0] good_total;
    logic [31:0] bad_total;

    result_t     due_results [$];
    int unsigned mismatches = 0;
    int unsigned items_applied = 0;

    // Idling and back-pressure controls set by the main sequence for sender and receiver.
    logic        sender_idles = 1'b1;
    logic        receiver_idles = 1'b1;
    logic        hold_pending = 1'b0;
    int unsigned squeeze_left = 0;

    function automatic int unsigned words_expected();
        return (cfg_count > MAX_REGISTERS) ? MAX_REGISTERS : cfg_count;
    endfunction

    // CRC-16/MODBUS, reflected, one byte LSB first
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] v;
        v = acc ^ {8'h00, b};
        repeat (8)
        begin
            if (v[0])
                v = (v >> 1) ^ CRC_POLY;
            else
                v = v >> 1;
        end
        return v;
    endfunction

    function automatic void clear_frame();
        frame_len_seen = 0;
        crc_acc = CRC_INIT;
        hdr_bytes[0] = 8'h00;
        hdr_bytes[1] = 8'h00;
        hdr_bytes[2] = 8'h00;
        hi_byte = 8'h00;
        last_two = 16'h0000;
        frame_closed = 1'b0;
    endfunction

    // Grade the frame in priority order: exception, length, CRC, header.
    function automatic result_t close_frame();
        int unsigned n;
        result_t     r;
        n = words_expected();
        r = NO_RESULT;
        r.kind = KIND_STATUS;
        if (frame_len_seen == 5 && hdr_bytes[0] == cfg_slave &&
            hdr_bytes[1] == FUNC_EXCEPTION_REPLY)
        begin
            r.status = ST_EXCEPTION;
            r.exception_code = hdr_bytes[2];
        end
        else if (frame_len_seen != 5 + 2 * n)
            r.status = ST_SHORT;
        else if (last_two != crc_acc)
            r.status = ST_CRC_ERROR;
        else if (hdr_bytes[0] != cfg_slave || hdr_bytes[1] != FUNC_READ_HOLDING ||
                 hdr_bytes[2] != 8'(2 * n))
            r.status = ST_HEADER_MISMATCH;
        else
            r.status = ST_OK;
        if (r.status == ST_OK)
            good_total = good_total + 1;
        else
            bad_total = bad_total + 1;
        r.byte_count = 8'(frame_len_seen);
        r.ok_total = good_total;
        r.error_total = bad_total;
        return r;
    endfunction

    // Advance the tracker by one accepted item; return 1 when it yields a result.
    function automatic logic track_item(input logic cmd, input logic [7:0] b,
                                        output result_t r);
        int unsigned full_len;
        int unsigned pos;
        logic        made;
        full_len = 5 + 2 * words_expected();
        made = 1'b0;
        r = NO_RESULT;
        if (cmd == CMD_FRAME_END)
        begin
            if (frame_closed)
            begin
                clear_frame();
                return 1'b0;
            end
            r = close_frame();
            clear_frame();
            return 1'b1;
        end
        if (frame_closed)
            return 1'b0;
        pos = frame_len_seen;
        if (pos < 3)
            hdr_bytes[pos] = b;
        // the two trailing CRC bytes stay out of the running CRC and the words
        if (pos + 2 < full_len)
        begin
            crc_acc = crc_step(crc_acc, b);
            if (pos >= 3)
            begin
                if (((pos - 3) & 1) == 0)
                    hi_byte = b;
                else
                begin
                    r.kind = KIND_WORD;
                    r.reg_index = 7'((pos - 4) >> 1);
                    r.reg_value = {hi_byte, b};
                    r.byte_count = 8'(pos + 1);
                    r.ok_total = good_total;
                    r.error_total = bad_total;
                    made = 1'b1;
                end
            end
        end
        last_two = {b, last_two[15:8]};
        frame_len_seen = pos + 1;
        if (frame_len_seen >= full_len)
        begin
            r = close_frame();
            frame_closed = 1'b1;
            made = 1'b1;
        end
        return made;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one item after a random or no gap, wait for the handshake, then queue
    // what it yields. A given status item overrides the tracker's.
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic use_given,
                             input result_t given);
        int unsigned gap;
        result_t     predicted;
        logic        produced;
        gap = 0;
        if (squeeze_left > 0)
            squeeze_left--;
        else if (sender_idles)
            gap = $urandom_range(0, 15);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.command <= cmd;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        if (!(cmd == CMD_BYTE && frame_closed))
            items_applied++;
        produced = track_item(cmd, b, predicted);
        if (use_given)
            due_results.push_back(given);
        else if (produced)
            due_results.push_back(predicted);
    endtask

    // Drop valid, drain every result and let silent items settle, then write.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        rx_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_SLAVE_ID)
            cfg_slave = value;
        else if (idx == CFG_WORD_COUNT)
            cfg_count = value[6:0];
    endtask

    // Send one frame for the current settings: a well-formed response with random
    // words, an exception reply, a damaged frame or noise.
    task automatic send_frame();
        logic [7:0]  bytes_q [$];
        int unsigned n;
        int unsigned pick;
        int unsigned cut;
        logic [15:0] c;
        n = words_expected();
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(0, 10)) bytes_q.push_back(8'($urandom));
        end
        else if (pick < 18)
        begin
            // exception reply, now and then from a foreign address
            if ($urandom_range(0, 3) == 0)
                bytes_q.push_back(8'($urandom));
            else
                bytes_q.push_back(cfg_slave);
            bytes_q.push_back(FUNC_EXCEPTION_REPLY);
            repeat (3) bytes_q.push_back(8'($urandom));
        end
        else
        begin
            bytes_q.push_back(cfg_slave);
            bytes_q.push_back(FUNC_READ_HOLDING);
            bytes_q.push_back(8'(2 * n));
            repeat (2 * n) bytes_q.push_back(8'($urandom));
            // damage one header bit and still seal it with a valid CRC
            if (pick < 28)
            begin
                cut = $urandom_range(0, 2);
                bytes_q[cut] = bytes_q[cut] ^ (8'h01 << $urandom_range(0, 7));
            end
            c = CRC_INIT;
            foreach (bytes_q[k])
                c = crc_step(c, bytes_q[k]);
            bytes_q.push_back(c[7:0]);
            bytes_q.push_back(c[15:8]);
            if (pick >= 28 && pick < 38)
            begin
                cut = $urandom_range(0, bytes_q.size() - 1);
                bytes_q[cut] = bytes_q[cut] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (pick >= 38 && pick < 50)
            begin
                cut = $urandom_range(1, bytes_q.size());
                repeat (cut) void'(bytes_q.pop_back());
            end
            else if (pick >= 50 && pick < 58)
            begin
                repeat ($urandom_range(1, 4)) bytes_q.push_back(8'($urandom));
            end
        end
        foreach (bytes_q[k])
            send_item(CMD_BYTE, bytes_q[k], 1'b0, NO_RESULT);
        // mostly close with a gap; otherwise let the next frame run into it
        if ($urandom_range(0, 9) != 0)
            send_item(CMD_FRAME_END, 8'($urandom), 1'b0, NO_RESULT);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    result_t head_result;

    // Compare every accepted result with the oldest one due.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0h index %0h",
                         $time, res_ch.kind, res_ch.reg_index);
                mismatches++;
            end
            else
            begin
                head_result = due_results.pop_front();
                check_field("kind", 32'(head_result.kind), 32'(res_ch.kind));
                check_field("reg_index", 32'(head_result.reg_index), 32'(res_ch.reg_index));
                check_field("reg_value", 32'(head_result.reg_value), 32'(res_ch.reg_value));
                check_field("status", 32'(head_result.status), 32'(res_ch.status));
                check_field("exception_code", 32'(head_result.exception_code),
                            32'(res_ch.exception_code));
                check_field("byte_count", 32'(head_result.byte_count),
                            32'(res_ch.byte_count));
                check_field("ok_total", head_result.ok_total, res_ch.ok_total);
                check_field("error_total", head_result.error_total, res_ch.error_total);
            end
        end
    end

    // Receiver: while idling, stall at random before each result, or hold
    // off for a long stretch once when asked so the block backs up its input.
    initial
    begin
        int unsigned stall;
        res_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            stall = 0;
            if (hold_pending)
            begin
                stall = 300;
                hold_pending = 1'b0;
            end
            else if (receiver_idles)
                stall = $urandom_range(0, 15);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (res_ch.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        script_row_t row;
        logic        cmd;
        logic [7:0]  value;
        result_t     given;
        int unsigned phase;
        int unsigned frames;
        logic        squeezed;
        logic [7:0]  slave_data;
        logic [7:0]  count_data;

        // Hold every input at a known value through reset.
        rst_n <= 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.command <= CMD_BYTE;
        rx_ch.rx_byte <= 8'h00;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_SLAVE_ID;
        cfg_ch.data <= 8'h00;

        cfg_slave = 8'd1;
        cfg_count = 7'd17;
        good_total = 32'd0;
        bad_total = 32'd0;
        clear_frame();
        squeezed = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the script. Fill the CRC rows from the running CRC so that good
        // frames need no precomputed check bytes.
        foreach (script[i])
        begin
            row = script[i];
            if (row.op == OP_SET_SLAVE)
                write_register(CFG_SLAVE_ID, row.value);
            else if (row.op == OP_SET_COUNT)
                write_register(CFG_WORD_COUNT, row.value);
            else
            begin
                cmd = (row.op == OP_END) ? CMD_FRAME_END : CMD_BYTE;
                case (row.op)
                    OP_CRC_LO:  value = crc_acc[7:0];
                    OP_CRC_BAD: value = crc_acc[7:0] ^ 8'hFF;
                    OP_CRC_HI:  value = crc_acc[15:8];
                    default:    value = row.value;
                endcase
                given = NO_RESULT;
                given.kind = KIND_STATUS;
                given.status = row.st;
                given.exception_code = row.code;
                given.byte_count = row.cnt;
                given.ok_total = 32'(row.ok);
                given.error_total = 32'(row.err);
                send_item(cmd, value, row.typed, given);
            end
        end

        // Random phases: new settings, then a batch of frames. Large register
        // counts get a single long frame; small counts get several.
        phase = 0;
        while (items_applied < ITEM_TARGET)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);

            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       slave_data = 8'h00;
                    1:       slave_data = 8'hFF;
                    default: slave_data = 8'($urandom);
                endcase
                if (phase == 0)
                    slave_data = 8'h00;
                write_register(CFG_SLAVE_ID, slave_data);
            end

            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                // bit 7 of the write is dropped; 126 and 127 saturate
                case ($urandom_range(0, 15))
                    0:       count_data = 8'd125;
                    1:       count_data = 8'($urandom_range(126, 127));
                    default: count_data = 8'($urandom_range(0, 6));
                endcase
                count_data[7] = 1'($urandom_range(0, 1));
                if (phase == 0)
                    count_data = 8'hFF;
                write_register(CFG_WORD_COUNT, count_data);
            end

            // Once, hold off the receiver while the sender keeps pushing.
            if (!squeezed && items_applied >= 600)
            begin
                hold_pending = 1'b1;
                squeeze_left = 120;
                squeezed = 1'b1;
            end

            frames = (words_expected() > 10) ? 1 : $urandom_range(3, 8);
            repeat (frames) send_frame();

            // Sometimes leave a frame open across the next register write.
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(CMD_BYTE, cfg_slave, 1'b0, NO_RESULT);
                send_item(CMD_BYTE, FUNC_READ_HOLDING, 1'b0, NO_RESULT);
                repeat ($urandom_range(0, 6))
                    send_item(CMD_BYTE, 8'($urandom), 1'b0, NO_RESULT);
            end
            phase++;
        end

        // Drain, then watch a little longer for stray results.
        rx_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Bound the run well beyond the slowest correct pass.
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== modbus_read_response_checker.f =====
design/mrrc_pkg.sv
design/mrrc_rx_if.sv
design/mrrc_res_if.sv
design/mrrc_cfg_if.sv
design/mrrc_in_stage.sv
design/mrrc_frame_core.sv
design/mrrc_out_stage.sv
design/modbus_read_response_checker.sv
tb/modbus_read_response_checker_tb.sv
